// ----- hw/rtl/pcpt_pkg.sv -----
// Shared types and constants for the polynomial curve proximity test core.
// No dependencies; every other file in hw/rtl imports this package.
`default_nettype none

package pcpt_pkg;

  // Default parameter values.
  localparam int MaxDegreeDefault = 3;
  localparam int MaxStepsDefault  = 4096;
  localparam int FracBitsDefault  = 16;

  // Configuration register indexes.
  localparam logic [2:0] REG_COEFF_ZERO   = 3'd0;
  localparam logic [2:0] REG_COEFF_ONE    = 3'd1;
  localparam logic [2:0] REG_COEFF_TWO    = 3'd2;
  localparam logic [2:0] REG_COEFF_THREE  = 3'd3;
  localparam logic [2:0] REG_POLY_DEGREE  = 3'd4;
  localparam logic [2:0] REG_SWEEP_START  = 3'd5;
  localparam logic [2:0] REG_SWEEP_END    = 3'd6;
  localparam logic [2:0] REG_PAD_DISTANCE = 3'd7;

  // Input transaction payload.
  typedef struct packed {
    logic signed [15:0] test_x;
    logic signed [15:0] test_y;
    logic signed [15:0] origin_x;
    logic signed [15:0] origin_y;
  } in_item_t;

  // Result transaction payload.
  typedef struct packed {
    logic hit;
    logic curve_found;
  } out_item_t;

  // Contents of the configuration registers.
  typedef struct packed {
    logic signed [31:0] coeff_zero;
    logic signed [31:0] coeff_one;
    logic signed [31:0] coeff_two;
    logic signed [31:0] coeff_three;
    logic [1:0]         poly_degree;
    logic signed [31:0] sweep_start;
    logic signed [31:0] sweep_end;
    logic [15:0]        pad_distance;
  } cfg_t;

  // Controller states.
  typedef enum logic [4:0] {
    ST_IDLE,
    ST_SWEEP,
    ST_F_INIT,
    ST_F_MUL,
    ST_F_ADD,
    ST_CHECK,
    ST_DF_INIT,
    ST_DF_MUL,
    ST_DF_ADD,
    ST_N_MUL,
    ST_TEST,
    ST_NEXT,
    ST_SQ_X,
    ST_SQ_Y,
    ST_SQ_PAD,
    ST_HIT,
    ST_MISS,
    ST_OUT
  } state_t;

  // Datapath operations.
  typedef enum logic [3:0] {
    OP_NONE,
    OP_LOAD,
    OP_F_INIT,
    OP_MUL_X,
    OP_F_ADD,
    OP_CHECK,
    OP_DF_INIT,
    OP_DF_ADD,
    OP_MUL_N,
    OP_NEXT,
    OP_SQ_X,
    OP_SQ_Y,
    OP_SQ_PAD,
    OP_HIT,
    OP_MISS
  } op_t;

  // Command from controller to datapath.
  typedef struct packed {
    op_t        op;
    logic [1:0] k;
  } cmd_t;

  // Status from datapath to controller.
  typedef struct packed {
    logic       more;
    logic       skip;
    logic       normal;
    logic [1:0] deg;
  } status_t;

endpackage

`default_nettype wire

// ----- hw/rtl/pcpt_cfg_regs.sv -----
// Configuration register file of the curve proximity core.
// Depends on pcpt_pkg for the register indexes and cfg_t.
`default_nettype none

module pcpt_cfg_regs (
  input  wire logic          clk,
  input  wire logic          rst_n,
  input  wire logic          cfg_we,
  input  wire logic [2:0]    cfg_idx,
  input  wire logic [31:0]   cfg_wdata,
  output pcpt_pkg::cfg_t     cfg
);
  import pcpt_pkg::*;

  cfg_t cfg_r;
  cfg_t cfg_nxt;

  // Decode a write into the addressed register.
  always_comb begin
    cfg_nxt = cfg_r;
    if (cfg_we) begin
      unique case (cfg_idx)
        REG_COEFF_ZERO:   cfg_nxt.coeff_zero   = cfg_wdata;
        REG_COEFF_ONE:    cfg_nxt.coeff_one    = cfg_wdata;
        REG_COEFF_TWO:    cfg_nxt.coeff_two    = cfg_wdata;
        REG_COEFF_THREE:  cfg_nxt.coeff_three  = cfg_wdata;
        REG_POLY_DEGREE:  cfg_nxt.poly_degree  = cfg_wdata[1:0];
        REG_SWEEP_START:  cfg_nxt.sweep_start  = cfg_wdata;
        REG_SWEEP_END:    cfg_nxt.sweep_end    = cfg_wdata;
        REG_PAD_DISTANCE: cfg_nxt.pad_distance = cfg_wdata[15:0];
        default:          cfg_nxt = cfg_r;
      endcase
    end
  end

  // All registers reset to zero.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r <= '0;
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

  assign cfg = cfg_r;

endmodule

`default_nettype wire

// ----- hw/rtl/pcpt_ctrl.sv -----
// Sequencing state machine of the curve proximity core.
// Depends on pcpt_pkg for state_t, cmd_t and status_t.
`default_nettype none

module pcpt_ctrl (
  input  wire logic          clk,
  input  wire logic          rst_n,
  input  wire logic          in_valid,
  output logic               in_stall,
  output logic               out_valid,
  input  wire logic          out_stall,
  input  pcpt_pkg::status_t  status,
  output pcpt_pkg::cmd_t     cmd
);
  import pcpt_pkg::*;

  state_t     state_r, state_nxt;
  logic [1:0] k_r, k_nxt;

  // Next state and Horner term index.
  always_comb begin
    state_nxt = state_r;
    k_nxt     = k_r;
    unique case (state_r)
      ST_IDLE:    if (in_valid) state_nxt = ST_SWEEP;
      ST_SWEEP:   state_nxt = status.more ? ST_F_INIT : ST_MISS;
      ST_F_INIT: begin
        k_nxt     = status.deg;
        state_nxt = (status.deg == 2'd0) ? ST_CHECK : ST_F_MUL;
      end
      ST_F_MUL:   state_nxt = ST_F_ADD;
      ST_F_ADD: begin
        k_nxt     = k_r - 2'd1;
        state_nxt = (k_r == 2'd1) ? ST_CHECK : ST_F_MUL;
      end
      ST_CHECK:   state_nxt = status.skip ? ST_NEXT : ST_DF_INIT;
      ST_DF_INIT: begin
        k_nxt     = status.deg - 2'd1;
        state_nxt = (status.deg <= 2'd1) ? ST_N_MUL : ST_DF_MUL;
      end
      ST_DF_MUL:  state_nxt = ST_DF_ADD;
      ST_DF_ADD: begin
        k_nxt     = k_r - 2'd1;
        state_nxt = (k_r == 2'd1) ? ST_N_MUL : ST_DF_MUL;
      end
      ST_N_MUL:   state_nxt = ST_TEST;
      ST_TEST:    state_nxt = status.normal ? ST_SQ_X : ST_NEXT;
      ST_NEXT:    state_nxt = ST_SWEEP;
      ST_SQ_X:    state_nxt = ST_SQ_Y;
      ST_SQ_Y:    state_nxt = ST_SQ_PAD;
      ST_SQ_PAD:  state_nxt = ST_HIT;
      ST_HIT:     state_nxt = ST_OUT;
      ST_MISS:    state_nxt = ST_OUT;
      ST_OUT:     if (!out_stall) state_nxt = ST_IDLE;
      default:    state_nxt = ST_IDLE;
    endcase
  end

  // Commands and handshake outputs.
  always_comb begin
    cmd.k     = k_r;
    cmd.op    = OP_NONE;
    in_stall  = (state_r != ST_IDLE);
    out_valid = (state_r == ST_OUT);
    unique case (state_r)
      ST_IDLE:    cmd.op = in_valid ? OP_LOAD : OP_NONE;
      ST_F_INIT:  cmd.op = OP_F_INIT;
      ST_F_MUL:   cmd.op = OP_MUL_X;
      ST_F_ADD:   cmd.op = OP_F_ADD;
      ST_CHECK:   cmd.op = OP_CHECK;
      ST_DF_INIT: cmd.op = OP_DF_INIT;
      ST_DF_MUL:  cmd.op = OP_MUL_X;
      ST_DF_ADD:  cmd.op = OP_DF_ADD;
      ST_N_MUL:   cmd.op = OP_MUL_N;
      ST_NEXT:    cmd.op = OP_NEXT;
      ST_SQ_X:    cmd.op = OP_SQ_X;
      ST_SQ_Y:    cmd.op = OP_SQ_Y;
      ST_SQ_PAD:  cmd.op = OP_SQ_PAD;
      ST_HIT:     cmd.op = OP_HIT;
      ST_MISS:    cmd.op = OP_MISS;
      default:    cmd.op = OP_NONE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
      k_r     <= 2'd0;
    end else begin
      state_r <= state_nxt;
      k_r     <= k_nxt;
    end
  end

endmodule

`default_nettype wire

// ----- hw/rtl/pcpt_datapath.sv -----
// Arithmetic datapath of the curve proximity core: sweep position, Horner
// evaluation on one shared multiplier, normal test and distance compare.
// Depends on pcpt_pkg for cmd_t, status_t, cfg_t and the payload types.
`default_nettype none

module pcpt_datapath #(
  parameter int MAX_DEGREE = pcpt_pkg::MaxDegreeDefault,
  parameter int MAX_STEPS  = pcpt_pkg::MaxStepsDefault,
  parameter int FRAC_BITS  = pcpt_pkg::FracBitsDefault
) (
  input  wire logic          clk,
  input  wire logic          rst_n,
  input  pcpt_pkg::cmd_t     cmd,
  output pcpt_pkg::status_t  status,
  input  pcpt_pkg::cfg_t     cfg,
  input  pcpt_pkg::in_item_t in_data,
  output pcpt_pkg::out_item_t out_data
);
  import pcpt_pkg::*;

  localparam int PW = 17 + FRAC_BITS;               // relative point, fixed point
  localparam int NW = $clog2(MAX_STEPS + 1);
  localparam logic signed [33:0] Step  = 34'((2 ** FRAC_BITS + 5) / 10);
  localparam logic signed [64:0] Eps   = 65'((2 ** FRAC_BITS + 5000) / 10000);
  localparam logic signed [32:0] Round = 33'(2 ** FRAC_BITS - 1);
  localparam logic [1:0] DegCap = (MAX_DEGREE >= 3) ? 2'd3 : 2'(MAX_DEGREE);
  localparam logic signed [64:0] SatHi = 65'sh0_7FFF_FFFF;
  localparam logic signed [64:0] SatLo = -65'sh0_8000_0000;

  // Saturate a wide sum to the signed 32-bit range.
  function automatic logic signed [31:0] sat32(input logic signed [64:0] v);
    logic signed [31:0] r;
    if (v > SatHi) begin
      r = 32'sh7FFF_FFFF;
    end else if (v < SatLo) begin
      r = 32'sh8000_0000;
    end else begin
      r = v[31:0];
    end
    return r;
  endfunction

  // Pick coefficient k.
  function automatic logic signed [31:0] coef_sel(input cfg_t c, input logic [1:0] k);
    logic signed [31:0] r;
    case (k)
      2'd0:    r = c.coeff_zero;
      2'd1:    r = c.coeff_one;
      2'd2:    r = c.coeff_two;
      default: r = c.coeff_three;
    endcase
    return r;
  endfunction

  // k times coefficient k, saturated.
  function automatic logic signed [31:0] dcoef(input cfg_t c, input logic [1:0] k);
    logic signed [64:0] v;
    logic signed [64:0] r;
    v = 65'(coef_sel(c, k));
    case (k)
      2'd0:    r = '0;
      2'd1:    r = v;
      2'd2:    r = v <<< 1;
      default: r = (v <<< 1) + v;
    endcase
    return sat32(r);
  endfunction

  logic signed [16:0] rx_r, ry_r;
  logic signed [PW-1:0] px_r, py_r;
  logic signed [33:0] x_r;
  logic [NW-1:0]      n_r;
  logic signed [31:0] acc_r, y_r, dn_r;
  logic signed [63:0] prod_r;
  logic [63:0]        sum_r;
  out_item_t          res_r;

  logic [1:0]         deg;
  logic signed [31:0] x32;
  logic signed [31:0] mul_a, mul_b;
  logic signed [64:0] prod_sh, hsum, dval, dabs;
  logic signed [65:0] tval, tabs, dnabs;
  logic signed [32:0] xadj, yadj, cx, cy;
  logic signed [33:0] dx, dy;

  assign deg = (cfg.poly_degree > DegCap) ? DegCap : cfg.poly_degree;
  assign x32 = x_r[31:0];

  // Horner partial sum: floor shift of the product plus a coefficient term.
  assign prod_sh = 65'(prod_r) >>> FRAC_BITS;
  always_comb begin
    if (cmd.op == OP_DF_ADD) begin
      hsum = prod_sh + 65'(dcoef(cfg, cmd.k));
    end else begin
      hsum = prod_sh + 65'(coef_sel(cfg, cmd.k - 2'd1));
    end
  end

  // Residual against the point, and the skip window.
  assign dval = 65'(acc_r) - 65'(py_r);
  assign dabs = (dval < 0) ? -dval : dval;

  // Normal condition without the division: 10*|t| < |dn|.
  assign tval  = 66'(prod_sh) + 66'(x32) - 66'(px_r);
  assign tabs  = (tval < 0) ? -tval : tval;
  assign dnabs = (dn_r < 0) ? -66'(dn_r) : 66'(dn_r);

  // Curve point truncated toward zero, and its offset from the point.
  assign xadj = 33'(x32) + ((x32 < 0) ? Round : 33'sd0);
  assign yadj = 33'(y_r) + ((y_r < 0) ? Round : 33'sd0);
  assign cx   = xadj >>> FRAC_BITS;
  assign cy   = yadj >>> FRAC_BITS;
  assign dx   = 34'(cx) - 34'(rx_r);
  assign dy   = 34'(cy) - 34'(ry_r);

  // Operand selection for the shared multiplier.
  always_comb begin
    mul_a = acc_r;
    mul_b = x32;
    case (cmd.op)
      OP_MUL_N: begin
        mul_a = acc_r;
        mul_b = dn_r;
      end
      OP_SQ_X: begin
        mul_a = dx[31:0];
        mul_b = dx[31:0];
      end
      OP_SQ_Y: begin
        mul_a = dy[31:0];
        mul_b = dy[31:0];
      end
      OP_SQ_PAD: begin
        mul_a = {16'd0, cfg.pad_distance};
        mul_b = {16'd0, cfg.pad_distance};
      end
      default: begin
        mul_a = acc_r;
        mul_b = x32;
      end
    endcase
  end

  // Status toward the controller.
  always_comb begin
    status.deg    = deg;
    status.more   = (n_r < NW'(MAX_STEPS)) && (x_r < 34'(cfg.sweep_end));
    status.skip   = (dabs <= Eps);
    status.normal = ((tabs <<< 3) + (tabs <<< 1)) < dnabs;
  end

  // Datapath registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      res_r <= '0;
    end else begin
      case (cmd.op)
        OP_HIT: begin
          res_r.hit         <= (sum_r <= 64'(prod_r));
          res_r.curve_found <= 1'b1;
        end
        OP_MISS: res_r <= '0;
        default: res_r <= res_r;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    case (cmd.op)
      OP_LOAD: begin
        rx_r <= 17'(in_data.test_x) - 17'(in_data.origin_x);
        ry_r <= 17'(in_data.test_y) - 17'(in_data.origin_y);
        px_r <= PW'(17'(in_data.test_x) - 17'(in_data.origin_x)) <<< FRAC_BITS;
        py_r <= PW'(17'(in_data.test_y) - 17'(in_data.origin_y)) <<< FRAC_BITS;
        x_r  <= 34'(cfg.sweep_start);
        n_r  <= '0;
      end
      OP_F_INIT: acc_r <= coef_sel(cfg, deg);
      OP_MUL_X, OP_MUL_N, OP_SQ_X: prod_r <= mul_a * mul_b;
      OP_F_ADD, OP_DF_ADD: acc_r <= sat32(hsum);
      OP_CHECK: begin
        y_r  <= acc_r;
        dn_r <= sat32(dval);
      end
      OP_DF_INIT: acc_r <= dcoef(cfg, deg);
      OP_NEXT: begin
        x_r <= x_r + Step;
        n_r <= n_r + NW'(1);
      end
      OP_SQ_Y: begin
        sum_r  <= 64'(prod_r);
        prod_r <= mul_a * mul_b;
      end
      OP_SQ_PAD: begin
        sum_r  <= sum_r + 64'(prod_r);
        prod_r <= mul_a * mul_b;
      end
      default: ;
    endcase
  end

  assign out_data = res_r;

endmodule

`default_nettype wire

// ----- hw/rtl/polynomial_curve_proximity_test_core.sv -----
// Top level of the polynomial curve proximity test core.
// Depends on pcpt_pkg, pcpt_cfg_regs, pcpt_ctrl and pcpt_datapath.
//
//   Channel  Ports                            Carries
//   in       in_valid, in_stall, in_data      test point and curve origin
//   out      out_valid, out_stall, out_data   hit and curve_found
//   cfg      cfg_we, cfg_idx, cfg_wdata       coefficients, degree, range, padding
//
// One query at a time. Each sample of the sweep runs Horner evaluation of the curve
// on the shared 32x32 multiplier and, unless the sample is skipped, of its
// derivative and the normal test; a query sweeps at most MAX_STEPS samples, and
// the distance compare after a found point uses the same multiplier.
// Reset is synchronous, active low, and clears all configuration to zero.
// in_stall stays high from acceptance until the result transaction leaves;
// a stalled result holds in out_data.
`default_nettype none

module polynomial_curve_proximity_test_core #(
  parameter int MAX_DEGREE = pcpt_pkg::MaxDegreeDefault,
  parameter int MAX_STEPS  = pcpt_pkg::MaxStepsDefault,
  parameter int FRAC_BITS  = pcpt_pkg::FracBitsDefault
) (
  input  wire logic           clk,
  input  wire logic           rst_n,
  input  wire logic           in_valid,
  output logic                in_stall,
  input  pcpt_pkg::in_item_t  in_data,
  output logic                out_valid,
  input  wire logic           out_stall,
  output pcpt_pkg::out_item_t out_data,
  input  wire logic           cfg_we,
  input  wire logic [2:0]     cfg_idx,
  input  wire logic [31:0]    cfg_wdata
);
  import pcpt_pkg::*;

  cfg_t    cfg;
  cmd_t    cmd;
  status_t status;

  // Configuration registers.
  pcpt_cfg_regs u_cfg (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_idx   (cfg_idx),
    .cfg_wdata (cfg_wdata),
    .cfg       (cfg)
  );

  // Sequencer.
  pcpt_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .status    (status),
    .cmd       (cmd)
  );

  // Arithmetic.
  pcpt_datapath #(
    .MAX_DEGREE (MAX_DEGREE),
    .MAX_STEPS  (MAX_STEPS),
    .FRAC_BITS  (FRAC_BITS)
  ) u_dp (
    .clk      (clk),
    .rst_n    (rst_n),
    .cmd      (cmd),
    .status   (status),
    .cfg      (cfg),
    .in_data  (in_data),
    .out_data (out_data)
  );

endmodule

`default_nettype wire

// ----- verif/testbench.sv -----
// Self-checking testbench for polynomial_curve_proximity_test_core.
// Depends on pcpt_pkg and the core RTL; a sweep predictor or typed row checks each result.
`default_nettype none

module testbench;
  import pcpt_pkg::*;

  localparam longint STEP_Q   = 6554;
  localparam longint THRESH_Q = 7;
  localparam int     SAMPLES  = 4096;
  localparam longint LIMIT    = 5000000;

  logic      clk;
  logic      rst_n;
  logic      in_valid;
  logic      in_stall;
  in_item_t  in_data;
  logic      out_valid;
  logic      out_stall;
  out_item_t out_data;
  logic      cfg_we;
  logic [2:0] cfg_idx;
  logic [31:0] cfg_wdata;

  polynomial_curve_proximity_test_core dut (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_stall(in_stall), .in_data(in_data),
    .out_valid(out_valid), .out_stall(out_stall), .out_data(out_data),
    .cfg_we(cfg_we), .cfg_idx(cfg_idx), .cfg_wdata(cfg_wdata)
  );

  // Shadow of the configuration registers, as the predictor sees them.
  cfg_t shadow;
  out_item_t pending_results[$];
  int errors, n_items, n_found, n_hits, n_results;
  longint cycles;
  bit quiet_sender;
  int sent_count;

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Watchdog on the total run length.
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > LIMIT) begin
      $display("Regression FAIL");
      $finish;
    end
  end

  function automatic longint clamp32(longint v);
    if (v > 64'sd2147483647) return 64'sd2147483647;
    if (v < -64'sd2147483648) return -64'sd2147483648;
    return v;
  endfunction

  function automatic longint coeff_at(int i);
    case (i)
      0: return longint'(shadow.coeff_zero);
      1: return longint'(shadow.coeff_one);
      2: return longint'(shadow.coeff_two);
      default: return longint'(shadow.coeff_three);
    endcase
  endfunction

  // Horner evaluation of the curve with floor shifts and saturation.
  function automatic longint curve_y(longint x);
    longint acc;
    int i;
    acc = coeff_at(shadow.poly_degree);
    for (i = shadow.poly_degree; i > 0; i--)
      acc = clamp32(((acc * x) >>> 16) + coeff_at(i - 1));
    return acc;
  endfunction

  // Horner evaluation of the derivative, using saturated i*c_i.
  function automatic longint curve_slope(longint x);
    longint acc;
    int i;
    int deg;
    deg = shadow.poly_degree;
    if (deg == 0) return 0;
    acc = clamp32(longint'(deg) * coeff_at(deg));
    for (i = deg - 1; i > 0; i--)
      acc = clamp32(((acc * x) >>> 16) + clamp32(longint'(i) * coeff_at(i)));
    return acc;
  endfunction

  // Sweeps the curve for the first sample normal to the point, then tests padding.
  function automatic out_item_t proximity_result(in_item_t it);
    out_item_t r;
    longint rx, ry, px, py, x, y, d, dn, t, cx, cy, dx, dy, abs_t, abs_dn;
    int n;
    r = '0;
    rx = longint'(it.test_x) - longint'(it.origin_x);
    ry = longint'(it.test_y) - longint'(it.origin_y);
    px = rx * 65536;
    py = ry * 65536;
    x = longint'(shadow.sweep_start);
    for (n = 0; n < SAMPLES && x < longint'(shadow.sweep_end); n++) begin
      y = curve_y(x);
      d = y - py;
      if ((d < 0 ? -d : d) > THRESH_Q) begin
        dn = clamp32(d);
        t = ((curve_slope(x) * dn) >>> 16) + (x - px);
        abs_t = t < 0 ? -t : t;
        abs_dn = dn < 0 ? -dn : dn;
        if (10 * abs_t < abs_dn) begin
          cx = x / 65536;
          cy = y / 65536;
          dx = cx - rx;
          dy = cy - ry;
          r.curve_found = 1'b1;
          r.hit = (dx * dx + dy * dy) <=
                  longint'(shadow.pad_distance) * longint'(shadow.pad_distance);
          break;
        end
      end
      x += STEP_Q;
    end
    return r;
  endfunction

  function automatic int signed_span(int span);
    return int'($urandom_range(0, 2 * span)) - span;
  endfunction

  // Result side: checks each transaction and stalls at random, with one long hold-off.
  int hold_left;
  bit pressure_done;
  always @(posedge clk) begin
    out_item_t want;
    if (rst_n && out_valid && !out_stall) begin
      n_results <= n_results + 1;
      if (pending_results.size() == 0) begin
        $display("%0t: unexpected result transaction hit=%b found=%b",
                 $time, out_data.hit, out_data.curve_found);
        errors <= errors + 1;
      end else begin
        want = pending_results.pop_front();
        if (want.hit !== out_data.hit) begin
          $display("%0t: hit mismatch, expected %b, got %b", $time, want.hit, out_data.hit);
          errors <= errors + 1;
        end
        if (want.curve_found !== out_data.curve_found) begin
          $display("%0t: curve_found mismatch, expected %b, got %b",
                   $time, want.curve_found, out_data.curve_found);
          errors <= errors + 1;
        end
      end
    end
    if (!pressure_done && sent_count >= 60) begin
      pressure_done <= 1'b1;
      hold_left <= 400;
      out_stall <= 1'b1;
    end else if (hold_left > 0) begin
      hold_left <= hold_left - 1;
      out_stall <= 1'b1;
    end else if ($urandom_range(0, 99) < 20) begin
      out_stall <= 1'b1;
      hold_left <= ($urandom_range(0, 9) == 0) ? int'($urandom_range(10, 60))
                                              : int'($urandom_range(0, 3));
    end else begin
      out_stall <= 1'b0;
    end
  end

  // Offers one input transaction, sometimes after a random gap, and waits for acceptance.
  task automatic send_query(in_item_t it);
    int gap;
    gap = 0;
    if (!quiet_sender && $urandom_range(0, 99) < 35)
      gap = ($urandom_range(0, 7) == 0) ? int'($urandom_range(20, 80))
                                        : int'($urandom_range(1, 4));
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data <= it;
    do @(posedge clk); while (in_stall);
    pending_results.push_back(proximity_result(it));
    n_items++;
    sent_count++;
  endtask

  // Waits for all results, then lets the core settle before a register write.
  task automatic drain();
    in_valid <= 1'b0;
    @(posedge clk);
    while (pending_results.size() != 0) @(posedge clk);
    repeat (8) @(posedge clk);
  endtask

  task automatic load_config(cfg_t c);
    logic [31:0] vals [8];
    int i;
    vals[REG_COEFF_ZERO]   = c.coeff_zero;
    vals[REG_COEFF_ONE]    = c.coeff_one;
    vals[REG_COEFF_TWO]    = c.coeff_two;
    vals[REG_COEFF_THREE]  = c.coeff_three;
    vals[REG_POLY_DEGREE]  = {30'd0, c.poly_degree};
    vals[REG_SWEEP_START]  = c.sweep_start;
    vals[REG_SWEEP_END]    = c.sweep_end;
    vals[REG_PAD_DISTANCE] = {16'd0, c.pad_distance};
    for (i = 0; i < 8; i++) begin
      cfg_we <= 1'b1;
      cfg_idx <= i[2:0];
      cfg_wdata <= vals[i];
      @(posedge clk);
    end
    cfg_we <= 1'b0;
    @(posedge clk);
    shadow = c;
  endtask

  // Directed stimulus: a settings index, the query, and a typed result where obvious.
  typedef struct {
    int        setting;
    in_item_t  item;
    bit        typed;
    out_item_t result;
  } directed_row_t;

  cfg_t settings [4];
  directed_row_t rows [$];

  task automatic add_row(int s, int tx, int ty, int ox, int oy, bit typed, bit h, bit f);
    directed_row_t r;
    r.setting = s;
    r.item = '{test_x: tx[15:0], test_y: ty[15:0], origin_x: ox[15:0], origin_y: oy[15:0]};
    r.typed = typed;
    r.result = '{hit: h, curve_found: f};
    rows.push_back(r);
  endtask

  initial begin
    int i, k, cur, ph, samples, span;
    longint rx, ry;
    cfg_t c;
    in_item_t it;

    rst_n = 1'b0;
    in_valid = 1'b0;
    in_data = '0;
    out_stall = 1'b0;
    cfg_we = 1'b0;
    cfg_idx = '0;
    cfg_wdata = '0;
    cycles = 0;
    errors = 0;
    hold_left = 0;
    pressure_done = 1'b0;
    quiet_sender = 1'b0;
    shadow = '0;
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Setting 0 is the reset state (empty sweep), 1 a unit-slope line,
    // 2 a saturating cubic over the full range, 3 a flat constant.
    settings[0] = '0;
    settings[1] = '{coeff_zero: 0, coeff_one: 32'sd65536, coeff_two: 0, coeff_three: 0,
                    poly_degree: 2'd1, sweep_start: -32'sd655360,
                    sweep_end: 32'sd655360, pad_distance: 16'd2};
    settings[2] = '{coeff_zero: 32'sh7fffffff, coeff_one: 32'sh80000000,
                    coeff_two: 32'sh7fffffff, coeff_three: 32'sh80000000,
                    poly_degree: 2'd3, sweep_start: 32'sh80000000,
                    sweep_end: 32'sh7fffffff, pad_distance: 16'hffff};
    settings[3] = '{coeff_zero: 32'sd327680, coeff_one: 0, coeff_two: 0, coeff_three: 0,
                    poly_degree: 2'd0, sweep_start: -32'sd131072,
                    sweep_end: 32'sd131072, pad_distance: 16'd0};

    // Empty sweep after reset: never a curve point, whatever the inputs.
    add_row(0, 0, 0, 0, 0, 1, 0, 0);
    add_row(0, 32767, 32767, -32768, -32768, 1, 0, 0);
    add_row(0, -32768, -32768, 32767, 32767, 1, 0, 0);
    add_row(0, -1, 32767, 0, -32768, 1, 0, 0);
    // Unit line: points on, near, and off the curve; a point exactly on a sample is skipped.
    add_row(1, 3, 3, 0, 0, 0, 0, 0);
    add_row(1, 3, 5, 0, 0, 0, 0, 0);
    add_row(1, 103, 95, 100, 100, 0, 0, 0);
    add_row(1, -10, -10, 0, 0, 0, 0, 0);
    add_row(1, 0, 8, 0, 0, 0, 0, 0);
    add_row(1, 20, -20, 0, 0, 0, 0, 0);
    add_row(1, -32768, 32767, -32768, 32767, 0, 0, 0);
    // Saturating cubic over the full range, maximum padding: long sweeps.
    add_row(2, 5, -5, 0, 0, 0, 0, 0);
    add_row(2, 32767, -32768, -32768, 32767, 0, 0, 0);
    // Constant curve with zero padding: only an exact hit counts.
    add_row(3, 0, 5, 0, 0, 0, 0, 0);
    add_row(3, 1, 9, 0, 0, 0, 0, 0);
    add_row(3, 0, 0, 0, 0, 0, 0, 0);
    add_row(3, 2, 5, 2, 0, 0, 0, 0);

    cur = 0;
    foreach (rows[i]) begin
      if (rows[i].setting != cur) begin
        drain();
        load_config(settings[rows[i].setting]);
        cur = rows[i].setting;
      end
      send_query(rows[i].item);
      if (rows[i].typed) begin
        void'(pending_results.pop_back());
        pending_results.push_back(rows[i].result);
      end
    end

    // Random phases: mostly points placed near the curve, some raw noise.
    for (ph = 0; ph < 12; ph++) begin
      drain();
      span = (ph == 5) ? 0 : 1;
      c.coeff_zero  = span ? signed_span(20 << 16) : $urandom;
      c.coeff_one   = span ? signed_span(3 << 16) : $urandom;
      c.coeff_two   = span ? signed_span(1 << 14) : $urandom;
      c.coeff_three = span ? signed_span(1 << 11) : $urandom;
      c.poly_degree = 2'(ph % 4);
      samples = ($urandom_range(0, 3) == 0) ? int'($urandom_range(40, 120))
                                            : int'($urandom_range(1, 40));
      c.sweep_start = signed_span(30 << 16);
      c.sweep_end = (ph == 7) ? 32'(c.sweep_start - $urandom_range(0, 65536))
                              : 32'(c.sweep_start + samples * STEP_Q);
      c.pad_distance = (ph == 2) ? 16'd0 : (ph == 9) ? 16'hffff
                                 : 16'($urandom_range(0, 6));
      load_config(c);
      quiet_sender = (ph % 3 == 0);
      for (k = 0; k < 24; k++) begin
        if ($urandom_range(0, 3) == 0) begin
          it = {$urandom, $urandom};
          it.origin_x = $urandom;
          it.origin_y = $urandom;
        end else begin
          rx = (longint'(c.sweep_start) >>> 16) + $urandom_range(0, samples / 10 + 1);
          ry = (curve_y(rx <<< 16) >>> 16) + signed_span(3);
          if (ry > 1000) ry = 1000;
          if (ry < -1000) ry = -1000;
          it.origin_x = 16'(signed_span(30000));
          it.origin_y = 16'(signed_span(30000));
          it.test_x = it.origin_x + 16'(rx);
          it.test_y = it.origin_y + 16'(ry);
        end
        send_query(it);
        if (pending_results[$].curve_found) n_found++;
        if (pending_results[$].hit) n_hits++;
      end
    end

    drain();
    repeat (50) @(posedge clk);
    $display("Ran %0d queries over directed and 12 random settings; %0d results checked.",
             n_items, n_results);
    $display("Random queries with a curve point: %0d, within padding: %0d.", n_found, n_hits);
    if (errors == 0 && pending_results.size() == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule

`default_nettype wire
